/* design/ccc_pkg.sv */
package ccc_pkg;

   localparam int UNIT_BITS = 16;

   localparam logic [UNIT_BITS-1:0] CH_CR = UNIT_BITS'(8'h0D);
   localparam logic [UNIT_BITS-1:0] CH_LF = UNIT_BITS'(8'h0A);
   localparam logic [UNIT_BITS-1:0] CH_DQ = UNIT_BITS'(8'h22);
   localparam logic [UNIT_BITS-1:0] CH_SQ = UNIT_BITS'(8'h27);
   localparam logic [UNIT_BITS-1:0] CH_BS = UNIT_BITS'(8'h5C);
   localparam logic [UNIT_BITS-1:0] CH_SL = UNIT_BITS'(8'h2F);
   localparam logic [UNIT_BITS-1:0] CH_ST = UNIT_BITS'(8'h2A);

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_DQ    = 3'd1,
      MODE_SQ    = 3'd2,
      MODE_LINE  = 3'd3,
      MODE_BLOCK = 3'd4
   } mode_type;

   typedef struct packed {
      logic [UNIT_BITS-1:0] unit;
      logic                 last;
   } item_type;

   typedef struct packed {
      logic [UNIT_BITS-1:0] unit;
      logic                 has_unit;
      logic                 end_of_text;
      logic                 text_changed;
   } rslt_type;

   typedef struct packed {
      logic [1:0] count;
      rslt_type   first;
      rslt_type   second;
   } pair_type;

endpackage

/* design/ccc_in_reg.sv */
module ccc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ccc_pkg::item_type  in_item,
   input  logic               advance,
   output logic               item_valid,
   output ccc_pkg::item_type  item
);

   logic              valid_ff;
   logic              valid_in;
   ccc_pkg::item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

/* design/ccc_scan.sv */
module ccc_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ccc_pkg::item_type  item,
   output ccc_pkg::pair_type  pair
);

   ccc_pkg::mode_type mode_ff, mode_in;
   logic slash_ff, slash_in;
   logic esc_ff, esc_in;
   logic star_ff, star_in;
   logic drop_ff, drop_in;

   logic [ccc_pkg::UNIT_BITS-1:0] u, u0, u1;
   logic [1:0] n;
   logic       eol;
   logic       marker;

   assign u   = item.unit;
   assign eol = (u == ccc_pkg::CH_CR) || (u == ccc_pkg::CH_LF);

   always_comb begin
      mode_in  = mode_ff;
      slash_in = slash_ff;
      esc_in   = esc_ff;
      star_in  = star_ff;
      drop_in  = drop_ff;
      n        = 2'd0;
      u0       = '0;
      u1       = '0;
      marker   = 1'b0;
      case (mode_ff)
         ccc_pkg::MODE_DQ, ccc_pkg::MODE_SQ: begin
            n  = 2'd1;
            u0 = u;
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (u == ccc_pkg::CH_BS) begin
               esc_in = 1'b1;
            end else if (eol || u == ((mode_ff == ccc_pkg::MODE_DQ) ? ccc_pkg::CH_DQ
                                                                   : ccc_pkg::CH_SQ)) begin
               mode_in = ccc_pkg::MODE_PLAIN;
            end
         end
         ccc_pkg::MODE_LINE: begin
            if (eol) begin
               n       = 2'd1;
               u0      = u;
               mode_in = ccc_pkg::MODE_PLAIN;
            end else begin
               drop_in = 1'b1;
            end
         end
         ccc_pkg::MODE_BLOCK: begin
            if (star_ff && u == ccc_pkg::CH_SL) begin
               n       = 2'd2;
               u0      = ccc_pkg::CH_ST;
               u1      = ccc_pkg::CH_SL;
               star_in = 1'b0;
               mode_in = ccc_pkg::MODE_PLAIN;
            end else begin
               if (star_ff) begin
                  drop_in = 1'b1;
               end
               star_in = 1'b0;
               if (item.last || eol) begin
                  n  = 2'd1;
                  u0 = u;
               end else if (u == ccc_pkg::CH_ST) begin
                  star_in = 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         default: begin
            mode_in  = ccc_pkg::MODE_PLAIN;
            slash_in = 1'b0;
            if (slash_ff && u == ccc_pkg::CH_ST) begin
               n       = 2'd2;
               u0      = ccc_pkg::CH_SL;
               u1      = ccc_pkg::CH_ST;
               mode_in = ccc_pkg::MODE_BLOCK;
               star_in = 1'b0;
            end else if (slash_ff && u == ccc_pkg::CH_SL) begin
               n       = 2'd2;
               u0      = ccc_pkg::CH_SL;
               u1      = ccc_pkg::CH_SL;
               mode_in = ccc_pkg::MODE_LINE;
            end else begin
               if (slash_ff) begin
                  n  = 2'd1;
                  u0 = ccc_pkg::CH_SL;
               end
               if (u == ccc_pkg::CH_SL) begin
                  slash_in = 1'b1;
               end else begin
                  if (slash_ff) begin
                     n  = 2'd2;
                     u1 = u;
                  end else begin
                     n  = 2'd1;
                     u0 = u;
                  end
                  if (u == ccc_pkg::CH_DQ) begin
                     mode_in = ccc_pkg::MODE_DQ;
                     esc_in  = 1'b0;
                  end else if (u == ccc_pkg::CH_SQ) begin
                     mode_in = ccc_pkg::MODE_SQ;
                     esc_in  = 1'b0;
                  end
               end
            end
         end
      endcase

      if (item.last) begin
         // flush a held slash, otherwise emit a bare end marker if nothing went out
         if (slash_in) begin
            n  = 2'd1;
            u0 = ccc_pkg::CH_SL;
         end else if (n == 2'd0) begin
            n      = 2'd1;
            marker = 1'b1;
         end
      end

      pair.count               = n;
      pair.first.unit          = u0;
      pair.first.has_unit      = !marker;
      pair.first.end_of_text   = item.last && (n == 2'd1);
      pair.first.text_changed  = item.last && (n == 2'd1) && drop_in;
      pair.second.unit         = u1;
      pair.second.has_unit     = 1'b1;
      pair.second.end_of_text  = item.last;
      pair.second.text_changed = item.last && drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ccc_pkg::MODE_PLAIN;
         slash_ff <= 1'b0;
         esc_ff   <= 1'b0;
         star_ff  <= 1'b0;
         drop_ff  <= 1'b0;
      end else if (advance) begin
         if (item.last) begin
            mode_ff  <= ccc_pkg::MODE_PLAIN;
            slash_ff <= 1'b0;
            esc_ff   <= 1'b0;
            star_ff  <= 1'b0;
            drop_ff  <= 1'b0;
         end else begin
            mode_ff  <= mode_in;
            slash_ff <= slash_in;
            esc_ff   <= esc_in;
            star_ff  <= star_in;
            drop_ff  <= drop_in;
         end
      end
   end

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      advance && item.last |-> pair.count != 2'd0)
      else $error("final unit produced no result");

   a_slash_only_plain: assert property (@(posedge clock) disable iff (reset)
      slash_ff |-> mode_ff == ccc_pkg::MODE_PLAIN)
      else $error("slash held outside plain text");

endmodule

/* design/ccc_res_buf.sv */
module ccc_res_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  ccc_pkg::pair_type  pair,
   output logic               free,
   output logic               out_valid,
   input  logic               out_ready,
   output ccc_pkg::rslt_type  out_rslt
);

   logic [1:0]        cnt_ff, cnt_in;
   ccc_pkg::rslt_type slot0_ff, slot0_in;
   ccc_pkg::rslt_type slot1_ff, slot1_in;
   logic              pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_rslt  = slot0_ff;
   assign pop       = out_valid && out_ready;
   assign free      = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
      if (load) begin
         slot0_in = pair.first;
         slot1_in = pair.second;
         cnt_in   = pair.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result pair loaded over pending results");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result count out of range");

endmodule

/* design/c_comment_compactor_unit.sv */
// Reduces C-style comments in a UTF-16 text stream to bare markers: a line
// comment to // with its line end kept, a block comment to /**/ with its CR and
// LF units kept; quoted literals pass unchanged. One code unit is taken per
// transfer on req_ with tlast marking the final unit of a buffer; the results
// leave on rsp_, the last one of a buffer flagged by tlast and carrying the
// dropped-anything flag. A unit is registered on input, then scanned with its
// results loaded into the result register. Sustained rate is one unit per cycle
// while each unit gives at most one result and rsp_tready holds high; a unit
// giving two results (after a held slash, or a closing star-slash) holds the
// next unit until its second result leaves the two-entry result register, which drains one transfer per cycle.
module c_comment_compactor_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ccc_pkg::UNIT_BITS-1:0] req_tdata,  // [15:0] code_unit
   input  logic                          req_tlast,  // final_unit
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ccc_pkg::UNIT_BITS-1:0] rsp_tdata,  // [15:0] out_unit
   output logic [1:0]                    rsp_tuser,  // [0] has_unit, [1] text_changed
   output logic                          rsp_tlast   // end_of_text
);

   ccc_pkg::item_type in_item;
   ccc_pkg::item_type item;
   ccc_pkg::pair_type pair;
   ccc_pkg::rslt_type rslt;
   logic              item_valid;
   logic              free;
   logic              advance;

   assign in_item.unit = req_tdata;
   assign in_item.last = req_tlast;
   assign advance      = item_valid && free;

   ccc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ccc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .pair    (pair)
   );

   ccc_res_buf u_res_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .pair      (pair),
      .free      (free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rslt  (rslt)
   );

   assign rsp_tdata = rslt.unit;
   assign rsp_tuser = {rslt.text_changed, rslt.has_unit};
   assign rsp_tlast = rslt.end_of_text;

endmodule

/* tb/sv/c_comment_compactor_unit_tb.sv */
module c_comment_compactor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_UNITS = 900;

   typedef struct {
      ccc_pkg::item_type item;
      bit                drain;
   } text_entry_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [ccc_pkg::UNIT_BITS-1:0] req_tdata = '0;
   logic                          req_tlast = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [ccc_pkg::UNIT_BITS-1:0] rsp_tdata;
   logic [1:0]                    rsp_tuser;
   logic                          rsp_tlast;

   text_entry_type    text_q[$];
   ccc_pkg::rslt_type compacted_q[$];
   ccc_pkg::rslt_type step_out[$];

   ccc_pkg::mode_type scan_mode;
   logic              slash_held;
   logic              escape_next;
   logic              star_seen;
   logic              dropped_any;

   int mismatches = 0;
   int rsp_count = 0;
   int cycle_count = 0;

   c_comment_compactor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   task automatic clear_scan();
      scan_mode   = ccc_pkg::MODE_PLAIN;
      slash_held  = 1'b0;
      escape_next = 1'b0;
      star_seen   = 1'b0;
      dropped_any = 1'b0;
   endtask

   task automatic keep(input logic [ccc_pkg::UNIT_BITS-1:0] u);
      ccc_pkg::rslt_type r;
      r.unit         = u;
      r.has_unit     = 1'b1;
      r.end_of_text  = 1'b0;
      r.text_changed = 1'b0;
      if (step_out.size() < 2)
         step_out.push_back(r);
   endtask

   task automatic plain_text(input logic [ccc_pkg::UNIT_BITS-1:0] u);
      if (u == ccc_pkg::CH_SL) begin
         slash_held = 1'b1;
      end else if (u == ccc_pkg::CH_DQ || u == ccc_pkg::CH_SQ) begin
         keep(u);
         scan_mode   = (u == ccc_pkg::CH_DQ) ? ccc_pkg::MODE_DQ : ccc_pkg::MODE_SQ;
         escape_next = 1'b0;
      end else begin
         keep(u);
      end
   endtask

   task automatic compact_unit(input logic [ccc_pkg::UNIT_BITS-1:0] u, input logic fin);
      logic              eol;
      ccc_pkg::rslt_type bare;
      eol = (u == ccc_pkg::CH_CR) || (u == ccc_pkg::CH_LF);
      step_out.delete();
      case (scan_mode)
         ccc_pkg::MODE_DQ, ccc_pkg::MODE_SQ: begin
            keep(u);
            if (escape_next)
               escape_next = 1'b0;
            else if (u == ccc_pkg::CH_BS)
               escape_next = 1'b1;
            else if (eol || u == ((scan_mode == ccc_pkg::MODE_DQ) ? ccc_pkg::CH_DQ
                                                                   : ccc_pkg::CH_SQ))
               scan_mode = ccc_pkg::MODE_PLAIN;
         end
         ccc_pkg::MODE_LINE: begin
            if (eol) begin
               keep(u);
               scan_mode = ccc_pkg::MODE_PLAIN;
            end else begin
               dropped_any = 1'b1;
            end
         end
         ccc_pkg::MODE_BLOCK: begin
            if (star_seen && u == ccc_pkg::CH_SL) begin
               keep(ccc_pkg::CH_ST);
               keep(ccc_pkg::CH_SL);
               star_seen = 1'b0;
               scan_mode = ccc_pkg::MODE_PLAIN;
            end else begin
               if (star_seen)
                  dropped_any = 1'b1;
               star_seen = 1'b0;
               if (fin)
                  keep(u);
               else if (u == ccc_pkg::CH_ST)
                  star_seen = 1'b1;
               else if (eol)
                  keep(u);
               else
                  dropped_any = 1'b1;
            end
         end
         default: begin
            scan_mode = ccc_pkg::MODE_PLAIN;
            if (slash_held) begin
               slash_held = 1'b0;
               if (u == ccc_pkg::CH_ST) begin
                  keep(ccc_pkg::CH_SL);
                  keep(ccc_pkg::CH_ST);
                  scan_mode = ccc_pkg::MODE_BLOCK;
                  star_seen = 1'b0;
               end else if (u == ccc_pkg::CH_SL) begin
                  keep(ccc_pkg::CH_SL);
                  keep(ccc_pkg::CH_SL);
                  scan_mode = ccc_pkg::MODE_LINE;
               end else begin
                  keep(ccc_pkg::CH_SL);
                  plain_text(u);
               end
            end else begin
               plain_text(u);
            end
         end
      endcase
      if (fin) begin
         if (slash_held)
            keep(ccc_pkg::CH_SL);
         if (step_out.size() == 0) begin
            bare = '0;
            step_out.push_back(bare);
         end
         step_out[step_out.size()-1].end_of_text  = 1'b1;
         step_out[step_out.size()-1].text_changed = dropped_any;
         clear_scan();
      end
      foreach (step_out[i])
         compacted_q.push_back(step_out[i]);
   endtask

   // ----------------------------------------------------------------- stimulus

   task automatic push_unit(input logic [ccc_pkg::UNIT_BITS-1:0] u, input logic fin);
      text_entry_type e;
      e.item.unit = u;
      e.item.last = fin;
      e.drain     = 1'b0;
      text_q.push_back(e);
   endtask

   task automatic push_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++)
         push_unit(ccc_pkg::UNIT_BITS'(s[i]), close && (i == s.len() - 1));
   endtask

   function automatic logic [ccc_pkg::UNIT_BITS-1:0] text_unit();
      case ($urandom_range(0, 7))
         0: return ccc_pkg::UNIT_BITS'($urandom_range(0, 65535));
         1: return ccc_pkg::UNIT_BITS'(16'h0020);
         default: return ccc_pkg::UNIT_BITS'(16'h0061 + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [ccc_pkg::UNIT_BITS-1:0] odd_unit();
      logic [ccc_pkg::UNIT_BITS-1:0] marks [7];
      marks[0] = ccc_pkg::CH_CR;
      marks[1] = ccc_pkg::CH_LF;
      marks[2] = ccc_pkg::CH_DQ;
      marks[3] = ccc_pkg::CH_SQ;
      marks[4] = ccc_pkg::CH_BS;
      marks[5] = ccc_pkg::CH_SL;
      marks[6] = ccc_pkg::CH_ST;
      case ($urandom_range(0, 3))
         0: return ccc_pkg::UNIT_BITS'($urandom_range(0, 65535));
         // look-alike: special low byte with a non-zero high byte
         1: return marks[$urandom_range(0, 6)] |
                   ccc_pkg::UNIT_BITS'($urandom_range(1, 255) << 8);
         default: return marks[$urandom_range(0, 6)];
      endcase
   endfunction

   function automatic logic [ccc_pkg::UNIT_BITS-1:0] line_end();
      return $urandom_range(0, 1) ? ccc_pkg::CH_LF : ccc_pkg::CH_CR;
   endfunction

   task automatic add_token();
      int                            kind;
      logic [ccc_pkg::UNIT_BITS-1:0] quote;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            repeat ($urandom_range(1, 6)) push_unit(text_unit(), 1'b0);
         end
         2: begin
            push_unit(ccc_pkg::CH_SL, 1'b0);
            push_unit(ccc_pkg::CH_SL, 1'b0);
            repeat ($urandom_range(0, 6)) push_unit(text_unit(), 1'b0);
            if ($urandom_range(0, 4) != 0)
               push_unit(line_end(), 1'b0);
         end
         3, 4: begin
            push_unit(ccc_pkg::CH_SL, 1'b0);
            push_unit(ccc_pkg::CH_ST, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 5))
                  0: push_unit(ccc_pkg::CH_ST, 1'b0);
                  1: push_unit(line_end(), 1'b0);
                  2: push_unit(ccc_pkg::CH_SL, 1'b0);
                  default: push_unit(text_unit(), 1'b0);
               endcase
            end
            if ($urandom_range(0, 9) != 0) begin
               push_unit(ccc_pkg::CH_ST, 1'b0);
               push_unit(ccc_pkg::CH_SL, 1'b0);
            end
         end
         5, 6: begin
            quote = (kind == 5) ? ccc_pkg::CH_DQ : ccc_pkg::CH_SQ;
            push_unit(quote, 1'b0);
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 4))
                  0: begin
                     push_unit(ccc_pkg::CH_BS, 1'b0);
                     push_unit(odd_unit(), 1'b0);
                  end
                  1: push_unit((kind == 5) ? ccc_pkg::CH_SQ : ccc_pkg::CH_DQ, 1'b0);
                  2: push_unit(ccc_pkg::CH_SL, 1'b0);
                  default: push_unit(text_unit(), 1'b0);
               endcase
            end
            case ($urandom_range(0, 7))
               0: push_unit(line_end(), 1'b0);
               1: ;
               default: push_unit(quote, 1'b0);
            endcase
         end
         7: begin
            repeat ($urandom_range(1, 4)) push_unit(odd_unit(), 1'b0);
         end
         8: push_unit(ccc_pkg::CH_SL, 1'b0);
         default: begin
            push_unit(ccc_pkg::CH_SL, 1'b0);
            push_unit($urandom_range(0, 1) ? ccc_pkg::CH_ST : odd_unit(), 1'b0);
         end
      endcase
   endtask

   // ------------------------------------------------------------------- sender

   always @(posedge clock) begin : tx_side
      int             burst_left;
      int             gap_left;
      logic           nxt_valid;
      text_entry_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         burst_left = $urandom_range(1, 48);
         gap_left   = 0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready)
            compact_unit(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               nxt_valid = 1'b0;
            end else if (text_q.size() == 0 ||
                         (text_q[0].drain && compacted_q.size() != 0)) begin
               nxt_valid = 1'b0;
            end else begin
               nxt = text_q.pop_front();
               req_tdata <= nxt.item.unit;
               req_tlast <= nxt.item.last;
               nxt_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // ----------------------------------------------------------------- receiver

   task automatic report_mismatch(input string what,
                                  input logic [ccc_pkg::UNIT_BITS-1:0] got,
                                  input logic [ccc_pkg::UNIT_BITS-1:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch on result %0d: %s got %h want %h", rsp_count, what, got, want);
   endtask

   always @(posedge clock) begin : rx_side
      int                hold_left;
      int                span_left;
      int                style;
      logic              rdy;
      ccc_pkg::rslt_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         span_left = 0;
         style     = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (compacted_q.size() == 0) begin
               report_mismatch("result with none expected", rsp_tdata, '0);
            end else begin
               want = compacted_q.pop_front();
               if (rsp_tdata !== want.unit)
                  report_mismatch("out_unit", rsp_tdata, want.unit);
               if (rsp_tuser[0] !== want.has_unit)
                  report_mismatch("has_unit", ccc_pkg::UNIT_BITS'(rsp_tuser[0]),
                                  ccc_pkg::UNIT_BITS'(want.has_unit));
               if (rsp_tuser[1] !== want.text_changed)
                  report_mismatch("text_changed", ccc_pkg::UNIT_BITS'(rsp_tuser[1]),
                                  ccc_pkg::UNIT_BITS'(want.text_changed));
               if (rsp_tlast !== want.end_of_text)
                  report_mismatch("end_of_text", ccc_pkg::UNIT_BITS'(rsp_tlast),
                                  ccc_pkg::UNIT_BITS'(want.end_of_text));
            end
            if (rsp_count == 200 || rsp_count == 600)
               hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            if (span_left <= 0) begin
               span_left = $urandom_range(8, 64);
               style     = $urandom_range(0, 3);
            end
            span_left--;
            case (style)
               0: rdy = 1'b1;
               1: rdy = $urandom_range(0, 1);
               2: rdy = ($urandom_range(0, 3) == 0);
               default: rdy = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_tready <= rdy;
      end
   end

   // -------------------------------------------------------------------- main

   initial begin : main
      int directed_len;
      clear_scan();

      // full-range units, then a slash left held at the end of the buffer
      push_unit(16'h0000, 1'b0);
      push_unit(16'hFFFF, 1'b0);
      push_text("/", 1'b1);
      // slash then letter, escaped quote ended by CR, line comment, block comment
      push_text("/x\"\\\"\015//q\n/**\n*/'", 1'b1);
      // unterminated block comment with a pending star before the final unit
      push_text("/**q", 1'b1);
      // line comment swallowing the final unit: bare end marker
      push_text("//k", 1'b1);
      directed_len = text_q.size();

      while (text_q.size() < directed_len + RANDOM_UNITS) begin
         repeat ($urandom_range(1, 6)) add_token();
         text_q[text_q.size()-1].item.last = 1'b1;
      end
      text_q[directed_len].drain = 1'b1;
      text_q[directed_len + RANDOM_UNITS / 2].drain = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (text_q.size() != 0 || req_tvalid || compacted_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* c_comment_compactor_unit.f */
design/ccc_pkg.sv
design/ccc_in_reg.sv
design/ccc_scan.sv
design/ccc_res_buf.sv
design/c_comment_compactor_unit.sv
tb/sv/c_comment_compactor_unit_tb.sv
